// ----- rtl/dbt_pkg.sv -----
// Shared types and constants for the depth buffer test block.
`default_nettype none

package dbt_pkg;

	// Depth format: signed Q1.22 in a 24-bit word
	localparam int DEPTH_W         = 24;
	localparam int DEPTH_FRAC_BITS = 22;
	localparam int READ_W          = 23;
	localparam int SUM_W           = DEPTH_W + 2;
	localparam int CFG_IDX_W       = 2;

	localparam logic signed [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1) << DEPTH_FRAC_BITS;
	localparam logic [READ_W-1:0]         READ_ONE  = READ_W'(1) << DEPTH_FRAC_BITS;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEST_EN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CMP_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_EN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_VAL = 2'd3;

	typedef enum logic [1:0] {
		KIND_FRAG  = 2'd0,
		KIND_MARK  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CMP_NEVER    = 3'd0,
		CMP_LESS     = 3'd1,
		CMP_EQUAL    = 3'd2,
		CMP_LEQUAL   = 3'd3,
		CMP_GREATER  = 3'd4,
		CMP_NOTEQUAL = 3'd5,
		CMP_GEQUAL   = 3'd6,
		CMP_ALWAYS   = 3'd7
	} cmp_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_CLEAR,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/dbt_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module dbt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0]  addr,
	input  wire logic [WIDTH-1:0]                              wdata,
	output      logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on enable, register the read of the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/depth_buffer_test.sv -----
// Top level: per-pixel depth store with depth test, region clear and readback.
//
// Usage: a command is accepted at a rising edge with start high and busy low.
// kind selects fragment test, mark clear pending, region clear or depth read.
// Every command yields exactly one result: done is high for one cycle with
// passed and read_depth valid; the receiver cannot stall and must take it.
// Configuration is written over cfg_valid/cfg_ready/cfg_index/cfg_data while
// the block is idle; cfg_ready is always high.
// A fragment test with the test enabled, or a readback, inside the buffer
// passes through ST_READ (address, registered RAM read) and ST_EVAL (compare
// and write back). Every other command, including a region clear with no
// clear pending or an empty region, goes through ST_FINISH only. A region
// clear of N > 0 pixels stays in ST_CLEAR, one pixel written per cycle, and
// raises done once the last pixel is written; busy stays high throughout,
// and the next command can be accepted in the cycle in which done is high.
// Reset clears the sequencer, the pending-clear flag and the configuration
// to its defaults; depth store contents are undefined until written.
`default_nettype none

module depth_buffer_test #(
	parameter int BUF_WIDTH  = 256,
	parameter int BUF_HEIGHT = 256
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Command channel
	input  wire logic                                 start,
	output      logic                                 busy,
	input  wire logic [1:0]                           kind,
	input  wire logic [7:0]                           x_pos,
	input  wire logic [7:0]                           y_pos,
	input  wire logic [8:0]                           x_end,
	input  wire logic [8:0]                           y_end,
	input  wire logic signed [dbt_pkg::DEPTH_W-1:0]   frag_depth,
	// Configuration channel
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [dbt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dbt_pkg::DEPTH_W-1:0]          cfg_data,
	// Result channel
	output      logic                                 done,
	output      logic                                 passed,
	output      logic [dbt_pkg::READ_W-1:0]           read_depth
);

	localparam int NUM_PIX = BUF_WIDTH * BUF_HEIGHT;
	localparam int ADDR_W  = (NUM_PIX > 2) ? $clog2(NUM_PIX) : 1;
	localparam int XCW     = ($clog2(BUF_WIDTH + 1) > 9) ? $clog2(BUF_WIDTH + 1) : 9;
	localparam int YCW     = ($clog2(BUF_HEIGHT + 1) > 9) ? $clog2(BUF_HEIGHT + 1) : 9;

	// Configuration registers
	logic                                test_en_q;
	dbt_pkg::cmp_mode_t                  cmp_mode_q;
	logic                                write_en_q;
	logic signed [dbt_pkg::DEPTH_W-1:0]  clear_val_q;

	// Sequencer and transaction registers
	dbt_pkg::state_t                     state_q, state_d;
	logic                                pending_q;
	dbt_pkg::kind_t                      kind_q;
	logic signed [dbt_pkg::DEPTH_W-1:0]  frag_q;
	logic [7:0]                          cx_q, cy_q, x0_q;
	logic [XCW-1:0]                      xs_q;
	logic [YCW-1:0]                      ys_q;

	// Result registers
	logic                                done_q;
	logic                                passed_q;
	logic [dbt_pkg::READ_W-1:0]          read_depth_q;

	// Combinational signals
	logic                                accept;
	logic                                in_inside;
	logic [XCW-1:0]                      in_xs;
	logic [YCW-1:0]                      in_ys;
	logic                                in_nonempty;
	logic                                col_last, row_last;
	logic [ADDR_W-1:0]                   ram_addr;
	logic                                ram_we;
	logic [dbt_pkg::DEPTH_W-1:0]         ram_wdata;
	logic [dbt_pkg::DEPTH_W-1:0]         ram_rdata;
	logic signed [dbt_pkg::DEPTH_W-1:0]  stored;
	logic                                cmp_pass;
	logic signed [dbt_pkg::SUM_W-1:0]    rd_sum;
	logic [dbt_pkg::READ_W-1:0]          rd_value;
	logic                                emit;
	logic                                res_passed;
	logic [dbt_pkg::READ_W-1:0]          res_depth;

	assign accept    = start && (state_q == dbt_pkg::ST_IDLE);
	assign busy      = (state_q != dbt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// Decode the incoming command geometry
	assign in_inside = (XCW'(x_pos) < XCW'(BUF_WIDTH)) && (YCW'(y_pos) < YCW'(BUF_HEIGHT));
	assign in_xs     = (XCW'(x_end) < XCW'(BUF_WIDTH)) ? XCW'(x_end) : XCW'(BUF_WIDTH);
	assign in_ys     = (YCW'(y_end) < YCW'(BUF_HEIGHT)) ? YCW'(y_end) : YCW'(BUF_HEIGHT);
	assign in_nonempty = (XCW'(x_pos) < in_xs) && (YCW'(y_pos) < in_ys);

	// Shared address unit: row times width plus column
	assign ram_addr = ADDR_W'(int'(cy_q) * BUF_WIDTH + int'(cx_q));
	assign col_last = ((XCW'(cx_q) + XCW'(1)) == xs_q);
	assign row_last = ((YCW'(cy_q) + YCW'(1)) == ys_q);

	// Shared compare unit: fragment against stored depth
	assign stored = $signed(ram_rdata);
	always_comb begin
		case (cmp_mode_q)
			dbt_pkg::CMP_NEVER:    cmp_pass = 1'b0;
			dbt_pkg::CMP_LESS:     cmp_pass = frag_q < stored;
			dbt_pkg::CMP_EQUAL:    cmp_pass = frag_q == stored;
			dbt_pkg::CMP_LEQUAL:   cmp_pass = frag_q <= stored;
			dbt_pkg::CMP_GREATER:  cmp_pass = frag_q > stored;
			dbt_pkg::CMP_NOTEQUAL: cmp_pass = frag_q != stored;
			dbt_pkg::CMP_GEQUAL:   cmp_pass = frag_q >= stored;
			default:               cmp_pass = 1'b1;
		endcase
	end

	// Map stored depth to (d + 1) / 2, saturated to [0, 1]
	assign rd_sum = dbt_pkg::SUM_W'(stored) + dbt_pkg::SUM_W'(dbt_pkg::DEPTH_ONE);
	always_comb begin
		if (rd_sum[dbt_pkg::SUM_W-1]) begin
			rd_value = '0;
		end else if (rd_sum[dbt_pkg::SUM_W-1:1] > (dbt_pkg::SUM_W-1)'(dbt_pkg::READ_ONE)) begin
			rd_value = dbt_pkg::READ_ONE;
		end else begin
			rd_value = rd_sum[dbt_pkg::READ_W:1];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dbt_pkg::ST_IDLE: begin
				if (start) begin
					case (dbt_pkg::kind_t'(kind))
						dbt_pkg::KIND_FRAG:
							state_d = (test_en_q && in_inside) ? dbt_pkg::ST_READ
								: dbt_pkg::ST_FINISH;
						dbt_pkg::KIND_READ:
							state_d = in_inside ? dbt_pkg::ST_READ : dbt_pkg::ST_FINISH;
						dbt_pkg::KIND_CLEAR:
							state_d = (pending_q && in_nonempty) ? dbt_pkg::ST_CLEAR
								: dbt_pkg::ST_FINISH;
						default:
							state_d = dbt_pkg::ST_FINISH;
					endcase
				end
			end
			dbt_pkg::ST_READ:   state_d = dbt_pkg::ST_EVAL;
			dbt_pkg::ST_EVAL:   state_d = dbt_pkg::ST_IDLE;
			dbt_pkg::ST_CLEAR:  state_d = (col_last && row_last) ? dbt_pkg::ST_IDLE
				: dbt_pkg::ST_CLEAR;
			dbt_pkg::ST_FINISH: state_d = dbt_pkg::ST_IDLE;
			default:            state_d = dbt_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: RAM control and result
	always_comb begin
		ram_we     = 1'b0;
		ram_wdata  = frag_q;
		emit       = 1'b0;
		res_passed = 1'b0;
		res_depth  = '0;
		case (state_q)
			dbt_pkg::ST_EVAL: begin
				emit = 1'b1;
				if (kind_q == dbt_pkg::KIND_FRAG) begin
					res_passed = cmp_pass;
					ram_we     = cmp_pass && write_en_q;
				end else begin
					res_depth = rd_value;
				end
			end
			dbt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = clear_val_q;
				emit      = col_last && row_last;
			end
			dbt_pkg::ST_FINISH: begin
				emit       = 1'b1;
				res_passed = (kind_q == dbt_pkg::KIND_FRAG) && !test_en_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer state and pending-clear flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dbt_pkg::ST_IDLE;
			pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (dbt_pkg::kind_t'(kind) == dbt_pkg::KIND_MARK)) begin
				pending_q <= 1'b1;
			end else if (accept && (dbt_pkg::kind_t'(kind) == dbt_pkg::KIND_CLEAR)) begin
				pending_q <= 1'b0;
			end
		end
	end

	// Latch the transaction and advance the sweep counters
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= dbt_pkg::kind_t'(kind);
			frag_q <= frag_depth;
			cx_q   <= x_pos;
			cy_q   <= y_pos;
			x0_q   <= x_pos;
			xs_q   <= in_xs;
			ys_q   <= in_ys;
		end else if (state_q == dbt_pkg::ST_CLEAR) begin
			if (col_last) begin
				cx_q <= x0_q;
				cy_q <= cy_q + 8'd1;
			end else begin
				cx_q <= cx_q + 8'd1;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_en_q   <= 1'b1;
			cmp_mode_q  <= dbt_pkg::CMP_LESS;
			write_en_q  <= 1'b1;
			clear_val_q <= dbt_pkg::DEPTH_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dbt_pkg::REG_TEST_EN:   test_en_q   <= cfg_data[0];
				dbt_pkg::REG_CMP_MODE:  cmp_mode_q  <= dbt_pkg::cmp_mode_t'(cfg_data[2:0]);
				dbt_pkg::REG_WRITE_EN:  write_en_q  <= cfg_data[0];
				dbt_pkg::REG_CLEAR_VAL: clear_val_q <= $signed(cfg_data);
				default:                test_en_q   <= test_en_q;
			endcase
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			passed_q     <= res_passed;
			read_depth_q <= res_depth;
		end
	end

	assign done       = done_q;
	assign passed     = passed_q;
	assign read_depth = read_depth_q;

	// Depth store
	dbt_ram #(
		.WIDTH (dbt_pkg::DEPTH_W),
		.DEPTH (NUM_PIX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// A result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != dbt_pkg::ST_IDLE))
		else $error("result strobe without a transaction in flight");

	// An accepted command always makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// The clear sweep stays inside the clipped region
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dbt_pkg::ST_CLEAR) |->
			((XCW'(cx_q) < xs_q) && (YCW'(cy_q) < ys_q)))
		else $error("clear sweep left its region");

	// A result never carries both a pass and a readback value
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(passed && (read_depth != '0)))
		else $error("pass flag and readback value in one result");

endmodule

`default_nettype wire
